[rtl/table_interpolator_unit_assert.svh]
// ----------------------------------------------------------------------------
// table interpolator assertion macros
// concurrent checks on clk, disabled while rst_n is low
// ----------------------------------------------------------------------------
`ifndef TABLE_INTERPOLATOR_UNIT_ASSERT_SVH
`define TABLE_INTERPOLATOR_UNIT_ASSERT_SVH

// same-cycle implication
`define TIP_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("table interpolator check failed");

// next-cycle implication
`define TIP_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("table interpolator check failed");

`endif

[rtl/tip_pkg.sv]
// ----------------------------------------------------------------------------
// tip_pkg
// shared types and constants of the table interpolator
// ----------------------------------------------------------------------------
package tip_pkg;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_QUERY = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    METH_LINEAR  = 2'd0,
    METH_PREV    = 2'd1,
    METH_NEXT    = 2'd2,
    METH_CLOSEST = 2'd3
  } method_t;

  typedef enum logic [1:0] {
    CFG_POINT_COUNT = 2'd0,
    CFG_METHOD      = 2'd1,
    CFG_LOG_X       = 2'd2,
    CFG_LOG_Y       = 2'd3
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_EMPTY    = 3'd1,
    ST_X_NONPOS = 3'd2,
    ST_NOT_ASC  = 3'd3,
    ST_Y_NONPOS = 3'd4,
    ST_NO_SPAN  = 3'd5
  } status_t;

  localparam logic [31:0] LOG10_2_Q32 = 32'd1292913986;
  localparam logic [31:0] LOG2_10_Q30 = 32'd3566893132;
  localparam logic signed [31:0] EXP_CLAMP = 32'sh0008_0000;
  localparam logic signed [31:0] Q16_TOP = 32'sh7FFF_FFFF;

  function automatic logic [31:0] isqrt64(input logic [63:0] a_in);
    logic [63:0] a;
    logic [63:0] res;
    logic [63:0] bt;
    a   = a_in;
    res = '0;
    bt  = 64'd1 << 62;
    for (int i = 0; i < 32; i++) begin
      if (a >= res + bt) begin
        a   = a - (res + bt);
        res = (res >> 1) + bt;
      end else begin
        res = res >> 1;
      end
      bt = bt >> 2;
    end
    return res[31:0];
  endfunction

  // k-th repeated square root of 2.0 in Q2.30
  function automatic logic [31:0] exp_root(input int k);
    logic [31:0] c;
    c = 32'h8000_0000;
    for (int j = 1; j <= 16; j++) begin
      if (j <= k) begin
        c = isqrt64(64'(c) << 30);
      end
    end
    return c;
  endfunction

endpackage

[rtl/tip_if.sv]
// ----------------------------------------------------------------------------
// tip channel interfaces
// valid/ready channels for input items and results
// ----------------------------------------------------------------------------
interface tip_in_if;
  logic               valid;
  logic               ready;
  logic               operation;
  logic [5:0]         point_index;
  logic signed [31:0] point_x;
  logic signed [31:0] point_y;
  logic signed [31:0] query_x;

  modport source (output valid, operation, point_index, point_x, point_y, query_x,
                  input ready);
  modport sink (input valid, operation, point_index, point_x, point_y, query_x,
                output ready);
endinterface

interface tip_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] result_y;
  logic [2:0]         status;

  modport source (output valid, result_y, status, input ready);
  modport sink (input valid, result_y, status, output ready);
endinterface

[rtl/table_interpolator_unit.sv]
// ----------------------------------------------------------------------------
// table_interpolator_unit
// piecewise linear or step lookup on signed Q16.16 breakpoints, with one
// shared multiplier, a bit-serial divider, log10 and 10^v sequences
//
//   channel   dir  fields                                          transfer
//   in_chan   in   operation point_index point_x point_y query_x  valid&ready
//   out_chan  out  result_y status                                 valid&ready
//   cfg_*     in   cfg_index cfg_wdata                             cfg_we
//
// in_chan is ready only while idle; a query holds it off until its result is
// registered for out_chan, running the scan, a division for a linear span, log10
// and 10^v in turn on the shared multiplier and the one memory read port
// reset is synchronous; the table holds no reset value and needs no clearing
// in_chan is taken while a finished result still waits on out_chan
// ----------------------------------------------------------------------------
`include "table_interpolator_unit_assert.svh"

module table_interpolator_unit #(
  parameter int TABLE_DEPTH = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  tip_in_if.sink     in_chan,
  tip_out_if.source  out_chan,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [6:0] cfg_wdata
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [4:0] {
    S_IDLE, S_RD_FIRST, S_CHK_FIRST, S_CHK_LAST, S_Q_LOGGED, S_SCAN_START,
    S_SCAN_P0, S_P0_LOGGED, S_SCAN_RD, S_SCAN_GET, S_X2_LOGGED, S_SCAN_CMP,
    S_LY1, S_LY2, S_DIV, S_LRP_MUL, S_LRP_FIN, S_LOG_INIT, S_LOG_SQ,
    S_LOG_NRM, S_LOG_SCL, S_LOG_FIN, S_EXP_MUL, S_EXP_T, S_EXP_STEP,
    S_EXP_ACC, S_EXP_FIN, S_FINISH
  } state_t;

  // configuration
  logic [6:0] cfg_count_r;
  logic [1:0] cfg_method_r;
  logic       cfg_logx_r;
  logic       cfg_logy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_count_r  <= '0;
      cfg_method_r <= '0;
      cfg_logx_r   <= 1'b0;
      cfg_logy_r   <= 1'b0;
    end else if (cfg_we) begin
      unique case (tip_pkg::cfg_idx_t'(cfg_index))
        tip_pkg::CFG_POINT_COUNT: cfg_count_r  <= cfg_wdata;
        tip_pkg::CFG_METHOD:      cfg_method_r <= cfg_wdata[1:0];
        tip_pkg::CFG_LOG_X:       cfg_logx_r   <= cfg_wdata[0];
        tip_pkg::CFG_LOG_Y:       cfg_logy_r   <= cfg_wdata[0];
      endcase
    end
  end

  // control state
  state_t state_r;
  state_t ret_r;
  logic   out_valid_r;
  logic signed [31:0] out_y_r;
  logic [2:0]         out_st_r;
  logic signed [31:0] res_y_r;
  logic [2:0]         res_st_r;

  logic [CW-1:0] n_r;
  logic [CW-1:0] idx_r;
  logic signed [31:0] qx_r, q_r;
  logic signed [31:0] x1_r, x2_r, y1_r, y2_r, lx1_r, lx2_r;
  logic signed [31:0] ya_r, yb_r;

  logic [32:0] div_den_r;
  logic [33:0] div_rem_r;
  logic [29:0] frac_r;
  logic [4:0]  div_k_r;

  logic [30:0] lg_arg_r;
  logic [4:0]  lg_p_r;
  logic [30:0] lg_m_r;
  logic [15:0] lg_frac_r;
  logic [3:0]  lg_k_r;
  logic        lg_neg_r;
  logic signed [31:0] lg_res_r;

  logic signed [31:0] ex_v_r;
  logic        ex_neg_r;
  logic [31:0] ex_r_r;
  logic signed [7:0] ex_ip_r;
  logic [15:0] ex_f_r;
  logic [3:0]  ex_k_r;

  // table memory, x in the upper half
  logic [63:0]   tbl_mem [TABLE_DEPTH];
  logic [63:0]   rd_data_r;
  logic [AW-1:0] rd_addr;
  logic [12:0]   wr_idx;
  logic          in_fire;

  assign in_fire = in_chan.valid && in_chan.ready;
  assign wr_idx  = 13'(in_chan.point_index);

  always_ff @(posedge clk) begin
    if (in_fire && tip_pkg::op_t'(in_chan.operation) == tip_pkg::OP_WRITE &&
        wr_idx < 13'(TABLE_DEPTH)) begin
      tbl_mem[wr_idx[AW-1:0]] <= {in_chan.point_x, in_chan.point_y};
    end
    rd_data_r <= tbl_mem[rd_addr];
  end

  // shared multiplier
  logic [32:0] mul_a;
  logic [31:0] mul_b;
  logic [64:0] mul_p_r;

  always_ff @(posedge clk) begin
    mul_p_r <= 65'(mul_a) * 65'(mul_b);
  end

  logic [31:0] root_tbl [16];
  for (genvar g = 0; g < 16; g++) begin : g_root
    assign root_tbl[g] = tip_pkg::exp_root(g + 1);
  end

  function automatic logic [4:0] msb_pos(input logic [30:0] v);
    logic [4:0] p;
    p = '0;
    for (int i = 0; i < 31; i++) begin
      if (v[i]) begin
        p = 5'(i);
      end
    end
    return p;
  endfunction

  // datapath
  logic signed [31:0] rd_x, rd_y, cx1, cx2;
  logic signed [32:0] d_lo, d_hi, dx, dy;
  logic [32:0]        ady;
  logic [CW-1:0]      nxt_idx;
  logic [CW-1:0]      last_idx;
  logic [12:0]        cnt_ext;
  logic [CW-1:0]      n_clamp;
  logic [33:0]        div_sh;
  logic               div_ge;
  logic [32:0]        lrp_d;
  logic [33:0]        lrp_sum;
  logic [4:0]         lg_p;
  logic [30:0]        lg_m0;
  logic [31:0]        lg_sq;
  logic signed [5:0]  lg_ps;
  logic signed [21:0] lg_l2;
  logic [21:0]        lg_abs;
  logic [64:0]        lg_rnd;
  logic signed [31:0] lg_val;
  logic signed [31:0] ex_vc;
  logic [19:0]        ex_abs;
  logic [64:0]        ex_rnd;
  logic signed [23:0] ex_t;
  logic [23:0]        ex_tu;
  logic [64:0]        ex_racc;
  logic [7:0]         ex_s;
  logic [32:0]        ex_tmp, ex_rs, ex_pick;
  logic signed [31:0] ex_out;

  assign rd_x = $signed(rd_data_r[63:32]);
  assign rd_y = $signed(rd_data_r[31:0]);
  assign cx1  = cfg_logx_r ? lx1_r : x1_r;
  assign cx2  = cfg_logx_r ? lx2_r : x2_r;
  assign d_lo = 33'(q_r) - 33'(cx1);
  assign d_hi = 33'(cx2) - 33'(q_r);
  assign dx   = 33'(cx2) - 33'(cx1);
  assign dy   = 33'(yb_r) - 33'(ya_r);
  assign ady  = dy[32] ? 33'(-dy) : 33'(dy);

  assign nxt_idx  = idx_r + CW'(1);
  assign last_idx = n_r - CW'(1);
  assign cnt_ext  = 13'(cfg_count_r);
  assign n_clamp  = (cnt_ext > 13'(TABLE_DEPTH)) ? CW'(TABLE_DEPTH) : CW'(cnt_ext);

  assign div_sh = {div_rem_r[32:0], 1'b0};
  assign div_ge = div_sh >= {1'b0, div_den_r};

  assign lrp_d   = mul_p_r[62:30];
  assign lrp_sum = dy[32] ? (34'(ya_r) - {1'b0, lrp_d}) : (34'(ya_r) + {1'b0, lrp_d});

  assign lg_p   = msb_pos(lg_arg_r);
  assign lg_m0  = lg_arg_r << (5'd30 - lg_p);
  assign lg_sq  = mul_p_r[61:30];
  assign lg_ps  = $signed({1'b0, lg_p_r}) - 6'sd16;
  assign lg_l2  = {lg_ps, lg_frac_r};
  assign lg_abs = lg_l2[21] ? 22'(-lg_l2) : 22'(lg_l2);
  assign lg_rnd = mul_p_r + (65'd1 << 31);
  assign lg_val = lg_neg_r ? -(32'(lg_rnd[51:32])) : 32'(lg_rnd[51:32]);

  assign ex_vc  = (ex_v_r > tip_pkg::EXP_CLAMP) ? tip_pkg::EXP_CLAMP :
                  (ex_v_r < -tip_pkg::EXP_CLAMP) ? -tip_pkg::EXP_CLAMP : ex_v_r;
  assign ex_abs = ex_vc[31] ? 20'(-ex_vc) : 20'(ex_vc);
  assign ex_rnd = mul_p_r + (65'd1 << 29);
  assign ex_t   = ex_neg_r ? -(24'(ex_rnd[51:30])) : 24'(ex_rnd[51:30]);
  assign ex_tu  = ex_t + 24'sh40_0000;
  assign ex_racc = mul_p_r + (65'd1 << 29);
  assign ex_s    = 8'sd14 - ex_ip_r;
  assign ex_tmp  = 33'(ex_r_r) >> (ex_s - 8'd1);
  assign ex_rs   = (ex_tmp + 33'd1) >> 1;
  assign ex_pick = (ex_s == 8'd0) ? 33'(ex_r_r) : ex_rs;
  assign ex_out  = (ex_ip_r >= 8'sd15 || ex_pick > 33'(tip_pkg::Q16_TOP)) ?
                   tip_pkg::Q16_TOP : $signed(ex_pick[31:0]);

  always_comb begin
    unique case (state_r)
      S_CHK_FIRST: rd_addr = last_idx[AW-1:0];
      S_SCAN_RD:   rd_addr = nxt_idx[AW-1:0];
      default:     rd_addr = '0;
    endcase
  end

  always_comb begin
    unique case (state_r)
      S_LOG_SQ: begin
        mul_a = 33'(lg_m_r);
        mul_b = 32'(lg_m_r);
      end
      S_LOG_SCL: begin
        mul_a = 33'(lg_abs);
        mul_b = tip_pkg::LOG10_2_Q32;
      end
      S_EXP_MUL: begin
        mul_a = 33'(ex_abs);
        mul_b = tip_pkg::LOG2_10_Q30;
      end
      S_EXP_STEP: begin
        mul_a = 33'(ex_r_r);
        mul_b = root_tbl[ex_k_r];
      end
      default: begin
        mul_a = ady;
        mul_b = 32'(frac_r);
      end
    endcase
  end

  assign in_chan.ready     = (state_r == S_IDLE);
  assign out_chan.valid    = out_valid_r;
  assign out_chan.result_y = out_y_r;
  assign out_chan.status   = out_st_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ret_r       <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (state_r != S_FINISH && out_valid_r && out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_fire && tip_pkg::op_t'(in_chan.operation) == tip_pkg::OP_QUERY) begin
            qx_r <= in_chan.query_x;
            q_r  <= in_chan.query_x;
            n_r  <= n_clamp;
            res_y_r <= '0;
            if (cfg_logx_r && in_chan.query_x <= 32'sd0) begin
              res_st_r <= tip_pkg::ST_X_NONPOS;
              state_r  <= S_FINISH;
            end else if (n_clamp == '0) begin
              res_st_r <= tip_pkg::ST_EMPTY;
              state_r  <= S_FINISH;
            end else begin
              state_r <= S_RD_FIRST;
            end
          end
        end
        S_RD_FIRST: state_r <= S_CHK_FIRST;
        S_CHK_FIRST: begin
          if (qx_r <= rd_x) begin
            res_y_r  <= rd_y;
            res_st_r <= tip_pkg::ST_OK;
            state_r  <= S_FINISH;
          end else begin
            state_r <= S_CHK_LAST;
          end
        end
        S_CHK_LAST: begin
          if (qx_r >= rd_x) begin
            res_y_r  <= rd_y;
            res_st_r <= tip_pkg::ST_OK;
            state_r  <= S_FINISH;
          end else if (cfg_logx_r) begin
            lg_arg_r <= qx_r[30:0];
            ret_r    <= S_Q_LOGGED;
            state_r  <= S_LOG_INIT;
          end else begin
            state_r <= S_SCAN_START;
          end
        end
        S_Q_LOGGED: begin
          q_r     <= lg_res_r;
          state_r <= S_SCAN_START;
        end
        S_SCAN_START: begin
          idx_r   <= '0;
          state_r <= S_SCAN_P0;
        end
        S_SCAN_P0: begin
          x1_r <= rd_x;
          y1_r <= rd_y;
          if (cfg_logx_r && rd_x > 32'sd0) begin
            lg_arg_r <= rd_x[30:0];
            ret_r    <= S_P0_LOGGED;
            state_r  <= S_LOG_INIT;
          end else begin
            state_r <= S_SCAN_RD;
          end
        end
        S_P0_LOGGED: begin
          lx1_r   <= lg_res_r;
          state_r <= S_SCAN_RD;
        end
        S_SCAN_RD: begin
          if (nxt_idx >= n_r) begin
            res_st_r <= tip_pkg::ST_NO_SPAN;
            state_r  <= S_FINISH;
          end else begin
            state_r <= S_SCAN_GET;
          end
        end
        S_SCAN_GET: begin
          x2_r <= rd_x;
          y2_r <= rd_y;
          if (cfg_logx_r && rd_x > 32'sd0) begin
            lg_arg_r <= rd_x[30:0];
            ret_r    <= S_X2_LOGGED;
            state_r  <= S_LOG_INIT;
          end else begin
            state_r <= S_SCAN_CMP;
          end
        end
        S_X2_LOGGED: begin
          lx2_r   <= lg_res_r;
          state_r <= S_SCAN_CMP;
        end
        S_SCAN_CMP: begin
          if ((cfg_logx_r && (x1_r <= 32'sd0 || x2_r <= 32'sd0)) || q_r >= cx2) begin
            x1_r    <= x2_r;
            y1_r    <= y2_r;
            lx1_r   <= lx2_r;
            idx_r   <= nxt_idx;
            state_r <= S_SCAN_RD;
          end else if (q_r < cx1) begin
            res_st_r <= tip_pkg::ST_NOT_ASC;
            state_r  <= S_FINISH;
          end else begin
            div_rem_r <= 34'(d_lo);
            div_den_r <= 33'(dx);
            div_k_r   <= '0;
            ya_r      <= y1_r;
            yb_r      <= y2_r;
            res_st_r  <= tip_pkg::ST_OK;
            unique case (tip_pkg::method_t'(cfg_method_r))
              tip_pkg::METH_LINEAR: begin
                if (!cfg_logy_r) begin
                  state_r <= S_DIV;
                end else if (y1_r <= 32'sd0 || y2_r <= 32'sd0) begin
                  res_st_r <= tip_pkg::ST_Y_NONPOS;
                  state_r  <= S_FINISH;
                end else begin
                  lg_arg_r <= y1_r[30:0];
                  ret_r    <= S_LY1;
                  state_r  <= S_LOG_INIT;
                end
              end
              tip_pkg::METH_PREV: begin
                res_y_r <= y1_r;
                state_r <= S_FINISH;
              end
              tip_pkg::METH_NEXT: begin
                res_y_r <= y2_r;
                state_r <= S_FINISH;
              end
              tip_pkg::METH_CLOSEST: begin
                res_y_r <= (d_lo < d_hi) ? y1_r : y2_r;
                state_r <= S_FINISH;
              end
            endcase
          end
        end
        S_LY1: begin
          ya_r     <= lg_res_r;
          lg_arg_r <= y2_r[30:0];
          ret_r    <= S_LY2;
          state_r  <= S_LOG_INIT;
        end
        S_LY2: begin
          yb_r    <= lg_res_r;
          state_r <= S_DIV;
        end
        S_DIV: begin
          div_rem_r <= div_ge ? (div_sh - {1'b0, div_den_r}) : div_sh;
          frac_r    <= {frac_r[28:0], div_ge};
          div_k_r   <= div_k_r + 5'd1;
          if (div_k_r == 5'd29) begin
            state_r <= S_LRP_MUL;
          end
        end
        S_LRP_MUL: state_r <= S_LRP_FIN;
        S_LRP_FIN: begin
          if (cfg_logy_r) begin
            ex_v_r  <= $signed(lrp_sum[31:0]);
            state_r <= S_EXP_MUL;
          end else begin
            res_y_r <= $signed(lrp_sum[31:0]);
            state_r <= S_FINISH;
          end
        end
        S_LOG_INIT: begin
          lg_p_r    <= lg_p;
          lg_m_r    <= lg_m0;
          lg_frac_r <= '0;
          lg_k_r    <= 4'd15;
          state_r   <= S_LOG_SQ;
        end
        S_LOG_SQ: state_r <= S_LOG_NRM;
        S_LOG_NRM: begin
          if (lg_sq[31]) begin
            lg_m_r            <= lg_sq[31:1];
            lg_frac_r[lg_k_r] <= 1'b1;
          end else begin
            lg_m_r <= lg_sq[30:0];
          end
          lg_k_r <= lg_k_r - 4'd1;
          if (lg_k_r == 4'd0) begin
            state_r <= S_LOG_SCL;
          end else begin
            state_r <= S_LOG_SQ;
          end
        end
        S_LOG_SCL: begin
          lg_neg_r <= lg_l2[21];
          state_r  <= S_LOG_FIN;
        end
        S_LOG_FIN: begin
          lg_res_r <= lg_val;
          state_r  <= ret_r;
        end
        S_EXP_MUL: begin
          ex_neg_r <= ex_vc[31];
          state_r  <= S_EXP_T;
        end
        S_EXP_T: begin
          ex_ip_r <= $signed({1'b0, ex_tu[22:16]}) - 8'sd64;
          ex_f_r  <= ex_tu[15:0];
          ex_r_r  <= 32'h4000_0000;
          ex_k_r  <= '0;
          state_r <= S_EXP_STEP;
        end
        S_EXP_STEP: begin
          if (ex_f_r[4'd15 - ex_k_r]) begin
            state_r <= S_EXP_ACC;
          end else if (ex_k_r == 4'd15) begin
            state_r <= S_EXP_FIN;
          end else begin
            ex_k_r <= ex_k_r + 4'd1;
          end
        end
        S_EXP_ACC: begin
          ex_r_r <= ex_racc[61:30];
          ex_k_r <= ex_k_r + 4'd1;
          if (ex_k_r == 4'd15) begin
            state_r <= S_EXP_FIN;
          end else begin
            state_r <= S_EXP_STEP;
          end
        end
        S_EXP_FIN: begin
          res_y_r <= ex_out;
          state_r <= S_FINISH;
        end
        S_FINISH: begin
          if (!out_valid_r || out_chan.ready) begin
            out_valid_r <= 1'b1;
            out_y_r     <= (res_st_r == tip_pkg::ST_OK) ? res_y_r : '0;
            out_st_r    <= res_st_r;
            state_r     <= S_IDLE;
          end
        end
      endcase
    end
  end

  `TIP_ASSERT_IMP(a_err_zero, out_chan.valid && out_chan.status != tip_pkg::ST_OK,
                  out_chan.result_y == 32'sd0)
  `TIP_ASSERT_NXT(a_query_busy, in_fire && in_chan.operation == tip_pkg::OP_QUERY,
                  state_r != S_IDLE)
  `TIP_ASSERT_NXT(a_finish_hold, state_r == S_FINISH && out_valid_r && !out_chan.ready,
                  state_r == S_FINISH && out_valid_r)

endmodule
